### src/half_step_stepper_positioner_core_assert.svh
// assertion macros shared by the half-step positioner rtl
`ifndef HALF_STEP_STEPPER_POSITIONER_CORE_ASSERT_SVH
`define HALF_STEP_STEPPER_POSITIONER_CORE_ASSERT_SVH

// clocked check, switched off while reset is high
`define HSSP_ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define HSSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/hssp_pkg.sv
// shared types, constants and the phase table of the half-step positioner
`default_nettype none

package hssp_pkg;

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int MAX_DIST_WIDTH     = 31;
  localparam int APB_ADDR_WIDTH     = 2;
  localparam int APB_DATA_WIDTH     = 32;

  localparam logic [APB_ADDR_WIDTH-1:0] ADDR_MAX_DIST = 2'd0;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SET_TARGET = 2'd1,
    OP_ZERO       = 2'd2,
    OP_GO         = 2'd3
  } op_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       move_up;
    logic       done;
    logic [3:0] coils;
  } ctrl_t;

  localparam ctrl_t CTRL_RESET = '{phase: 3'd0, move_up: 1'b1, done: 1'b0, coils: 4'd0};

  localparam logic [3:0] COILS_OFF = 4'b0000;

  // eight-phase half-step drive pattern
  function automatic logic [3:0] phase_pattern(input logic [2:0] idx);
    logic [3:0] pat;
    case (idx)
      3'd0:    pat = 4'b0001;
      3'd1:    pat = 4'b0011;
      3'd2:    pat = 4'b0010;
      3'd3:    pat = 4'b0110;
      3'd4:    pat = 4'b0100;
      3'd5:    pat = 4'b1100;
      3'd6:    pat = 4'b1000;
      3'd7:    pat = 4'b1001;
      default: pat = COILS_OFF;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

### src/hssp_cmd_unit.sv
// command logic: next position, target and phase state for one word
`default_nettype none

module hssp_cmd_unit #(
  parameter int POSITION_WIDTH = hssp_pkg::POSITION_WIDTH_DEF
) (
  input  hssp_pkg::op_t                          op,
  input  logic signed [31:0]                     target_value,
  input  logic                                   go_direction,
  input  logic [hssp_pkg::MAX_DIST_WIDTH-1:0]    max_dist,
  input  logic [POSITION_WIDTH-1:0]              pos,
  input  logic [POSITION_WIDTH-1:0]              tgt,
  input  hssp_pkg::ctrl_t                        ctrl,
  output logic [POSITION_WIDTH-1:0]              pos_next,
  output logic [POSITION_WIDTH-1:0]              tgt_next,
  output hssp_pkg::ctrl_t                        ctrl_next
);

  logic [63:0]               tv_ext;
  logic [63:0]               md_ext;
  logic [POSITION_WIDTH-1:0] go_span;
  logic [POSITION_WIDTH-1:0] new_tgt;
  logic [POSITION_WIDTH-1:0] base_pos;
  logic                      load;
  logic                      at_target;

  assign tv_ext    = 64'(target_value);
  assign md_ext    = 64'(max_dist);
  assign go_span   = md_ext[POSITION_WIDTH-1:0];
  assign at_target = (pos == tgt);

  // target and base position for the load commands
  always_comb begin
    load     = 1'b1;
    base_pos = pos;
    new_tgt  = tgt;
    case (op)
      hssp_pkg::OP_TICK: begin
        load = 1'b0;
      end
      hssp_pkg::OP_SET_TARGET: begin
        new_tgt = tv_ext[POSITION_WIDTH-1:0];
      end
      hssp_pkg::OP_ZERO: begin
        base_pos = '0;
        new_tgt  = '0;
      end
      hssp_pkg::OP_GO: begin
        new_tgt = go_direction ? (pos + go_span) : (pos - go_span);
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_comb begin
    pos_next  = pos;
    tgt_next  = tgt;
    ctrl_next = ctrl;
    if (load) begin
      pos_next          = base_pos;
      tgt_next          = new_tgt;
      ctrl_next.done    = 1'b0;
      ctrl_next.move_up = ($signed(new_tgt) > $signed(base_pos));
    end else if (at_target) begin
      ctrl_next.coils = hssp_pkg::COILS_OFF;
      ctrl_next.done  = 1'b1;
    end else begin
      ctrl_next.coils = hssp_pkg::phase_pattern(ctrl.phase);
      if (ctrl.move_up) begin
        ctrl_next.phase = ctrl.phase + 3'd1;
        pos_next        = pos + POSITION_WIDTH'(1);
      end else begin
        ctrl_next.phase = ctrl.phase - 3'd1;
        pos_next        = pos - POSITION_WIDTH'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/half_step_stepper_positioner_core.sv
// top level of the half-step stepper positioner
`default_nettype none

// Half-step stepper positioner. Each command word (tick, set target, zero,
// go relative) gives exactly one result word: the coil pattern, the finished
// flag and the position after the command. Words flow at one per clock
// cycle unless res_ready stalls them: the input register captures the
// command, the command logic (adders, compares, the phase table) updates the
// motor state and fills the result register. The two registers decouple the
// sides, so a new command is taken while a finished result still waits, if
// the input register is free. max_dist lives at APB byte address 0 and should
// only be written while no command is in flight. Position is POSITION_WIDTH
// bits wide and wraps; the position port shows it sign-extended and cut to 32
// bits. No clearing pass after reset.

`include "half_step_stepper_positioner_core_assert.svh"

module half_step_stepper_positioner_core #(
  parameter int POSITION_WIDTH = hssp_pkg::POSITION_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // command channel
  input  logic                                  cmd_valid,
  output logic                                  cmd_ready,
  input  logic [1:0]                            opcode,
  input  logic signed [31:0]                    target_value,
  input  logic                                  go_direction,
  // result channel
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output logic [3:0]                            coils,
  output logic                                  finished,
  output logic signed [31:0]                    position,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [hssp_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  logic [hssp_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic [hssp_pkg::APB_DATA_WIDTH-1:0]   prdata,
  output logic                                  pready
);

  // configuration register
  logic [hssp_pkg::MAX_DIST_WIDTH-1:0] max_dist;
  logic                                cfg_write;

  // input register
  logic               stage_valid;
  hssp_pkg::op_t      stage_op;
  logic signed [31:0] stage_target;
  logic               stage_dir;

  // motor state
  logic [POSITION_WIDTH-1:0] pos;
  logic [POSITION_WIDTH-1:0] tgt;
  hssp_pkg::ctrl_t           ctrl;

  // command logic outputs
  logic [POSITION_WIDTH-1:0] pos_next;
  logic [POSITION_WIDTH-1:0] tgt_next;
  hssp_pkg::ctrl_t           ctrl_next;
  logic [63:0]               pos_ext;

  logic cmd_fire;
  logic stage_fire;

  // apb: always ready, one register at address zero
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr == hssp_pkg::ADDR_MAX_DIST);
  assign prdata    = (paddr == hssp_pkg::ADDR_MAX_DIST) ?
                     hssp_pkg::APB_DATA_WIDTH'(max_dist) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_dist <= '0;
    end else if (cfg_write) begin
      max_dist <= pwdata[hssp_pkg::MAX_DIST_WIDTH-1:0];
    end
  end

  // handshake: the stage moves on when the result register is free or drains
  assign stage_fire = stage_valid && (!res_valid || res_ready);
  assign cmd_ready  = !stage_valid || stage_fire;
  assign cmd_fire   = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd_ready) begin
      stage_valid <= cmd_valid;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      stage_op     <= hssp_pkg::op_t'(opcode);
      stage_target <= target_value;
      stage_dir    <= go_direction;
    end
  end

  hssp_cmd_unit #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_cmd (
    .op           (stage_op),
    .target_value (stage_target),
    .go_direction (stage_dir),
    .max_dist     (max_dist),
    .pos          (pos),
    .tgt          (tgt),
    .ctrl         (ctrl),
    .pos_next     (pos_next),
    .tgt_next     (tgt_next),
    .ctrl_next    (ctrl_next)
  );

  // motor state commits when the word leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      tgt  <= '0;
      ctrl <= hssp_pkg::CTRL_RESET;
    end else if (stage_fire) begin
      pos  <= pos_next;
      tgt  <= tgt_next;
      ctrl <= ctrl_next;
    end
  end

  // position reported sign-extended, then cut to the 32-bit port
  assign pos_ext = 64'($signed(pos_next));

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (stage_fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire) begin
      coils    <= ctrl_next.coils;
      finished <= ctrl_next.done;
      position <= pos_ext[31:0];
    end
  end

  // nothing is pending straight after reset
  `HSSP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!res_valid && !stage_valid),
    "result or input register valid after reset")

  // finished means parked on target with coils released
  `HSSP_ASSERT_CLK(a_done_parked, clk, rst,
    ctrl.done |-> ((pos == tgt) && (ctrl.coils == hssp_pkg::COILS_OFF)),
    "done flag set away from target or with coils driven")

  // a moving tick steps the phase by exactly one
  `HSSP_ASSERT_CLK(a_phase_step, clk, rst,
    (stage_fire && (stage_op == hssp_pkg::OP_TICK) && (pos != tgt)) |=>
      ((ctrl.phase == ($past(ctrl.phase) + 3'd1)) ||
       (ctrl.phase == ($past(ctrl.phase) - 3'd1))),
    "phase did not move by one half-step on a tick")

  // a result is presented only after a word has passed the input register
  `HSSP_ASSERT_CLK(a_result_source, clk, rst,
    $rose(res_valid) |-> $past(stage_valid),
    "result appeared without a word in the input register")

endmodule

`default_nettype wire
